@@ rtl/core/bsg_pkg.sv @@
package bsg_pkg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQR  = 6'b000010,
        ST_ROOT = 6'b000100,
        ST_DEC  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

endpackage

@@ rtl/core/bsg_if.sv @@
interface bsg_if #(
    parameter int W = 1
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/bsg_sqrt.sv @@
module bsg_sqrt #(
    parameter int SW = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SW-1:0]   i_value,
    output logic            o_done,
    output logic [SW/2-1:0] o_root
);
    localparam int RW = SW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_val;
    logic [RW-1:0]  r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [SW+1:0]  w_trial;
    logic [SW+1:0]  w_rem2;

    assign w_rem2  = {r_rem, r_val[SW-1 -: 2]};
    assign w_trial = {{(SW-RW){1'b0}}, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_val  <= i_value;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SW-3:0], 2'b00};
            if (w_rem2 >= w_trial) begin
                r_rem  <= SW'(w_rem2 - w_trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= SW'(w_rem2);
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ rtl/core/bsg_muldiv.sv @@
module bsg_muldiv #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_d,
    output logic         o_done,
    output logic [W-1:0] o_q
);
    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW + 2);

    logic [PW-1:0] r_num;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_mul;
    logic          r_done;
    logic [W:0]    w_rem2;

    assign w_rem2 = {r_rem[W-1:0], r_num[PW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_mul <= 1'b1;
        end else if (r_mul) begin
            r_mul  <= 1'b0;
            r_busy <= 1'b1;
            r_cnt  <= CW'(PW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_a * i_b;
            r_rem <= '0;
            r_d   <= i_d;
        end else if (r_busy) begin
            if (w_rem2 >= {1'b0, r_d}) begin
                r_rem <= w_rem2 - {1'b0, r_d};
                r_num <= {r_num[PW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2;
                r_num <= {r_num[PW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_num[W-1:0];
endmodule

@@ rtl/core/bounding_sphere_grow_core.sv @@
// Incremental bounding sphere.
// Input channel s_in carries restart, item_x/y/z and item_radius; output
// channel m_out carries center_x/y/z_out, radius_out and grew. Both are
// valid/ready, a transaction moves when both are high.
// One item is handled at a time: s_in.ready is high only while idle.
// An item that restarts or finds the store empty gives its result the cycle
// after acceptance. Otherwise the item runs three squares, a square root (one
// result bit a cycle), a decision, then each axis of a moving center runs a
// multiply-then-restoring-divide on one shared unit.
// The result sits in an output register until taken; while the receiver
// stalls no new item is accepted.
// Reset empties the sphere and clears the center and radius to zero.
module bounding_sphere_grow_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bsg_if.sink   s_in,
    bsg_if.source m_out
);
    localparam int CW = COORD_WIDTH;
    localparam int RW = CW - 1;
    localparam int SW = 2 * CW;

    logic [CW-1:0] r_cx, r_cy, r_cz, r_ix, r_iy, r_iz;
    logic [RW-1:0] r_rad, r_ir, r_orad;
    logic [CW-1:0] r_ox, r_oy, r_oz;
    logic          r_empty, r_valid;
    logic [SW-1:0] r_sum;
    logic [1:0]    r_ax;
    logic [CW:0]   r_dist;
    logic [CW-1:0] r_g;
    bsg_pkg::t_state r_st;

    logic          w_restart;
    logic [CW-1:0] w_x, w_y, w_z;
    logic [RW-1:0] w_r;
    assign {w_restart, w_x, w_y, w_z, w_r} = s_in.data;

    logic [CW-1:0] w_c, w_t;
    logic [CW:0]   w_diff;
    logic [CW-1:0] w_mag;
    logic          w_ge;
    always_comb begin
        unique case (r_ax)
            2'd0:    begin w_c = r_cx; w_t = r_ix; end
            2'd1:    begin w_c = r_cy; w_t = r_iy; end
            default: begin w_c = r_cz; w_t = r_iz; end
        endcase
        w_diff = {w_t[CW-1], w_t} - {w_c[CW-1], w_c};
        w_ge   = !w_diff[CW];
        w_mag  = w_ge ? w_diff[CW-1:0] : CW'(-w_diff);
    end

    logic [SW-1:0] w_sq;
    logic [SW:0]   w_add;
    assign w_sq  = w_mag * w_mag;
    assign w_add = {1'b0, r_sum} + {1'b0, w_sq};

    logic          w_sq_done;
    logic [CW-1:0] w_root;
    logic          w_sqrt_start;
    assign w_sqrt_start = (r_st == bsg_pkg::ST_SQR) && (r_ax == 2'd2);
    bsg_sqrt #(.SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_add[SW] ? {SW{1'b1}} : w_add[SW-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    logic          w_div_start, w_div_done;
    logic [CW-1:0] w_q;
    logic          r_div_run;
    assign w_div_start = (r_st == bsg_pkg::ST_DIV) && !r_div_run;
    bsg_muldiv #(.W(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (w_mag),
        .i_b     (r_g),
        .i_d     (r_dist[CW-1:0]),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    logic [CW+1:0] w_in_sum, w_enc_sum, w_nr_full;
    logic [CW:0]   w_nr;
    logic [CW:0]   w_gr;
    always_comb begin
        w_in_sum  = {2'b0, r_dist[CW-1:0]} + (CW+2)'(r_ir);
        w_enc_sum = {2'b0, r_dist[CW-1:0]} + (CW+2)'(r_rad);
        w_nr_full = (w_in_sum + (CW+2)'(r_rad)) >> 1;
        w_nr      = (w_nr_full > (CW+2)'({RW{1'b1}})) ? (CW+1)'({RW{1'b1}})
                                                       : w_nr_full[CW:0];
        w_gr      = (w_nr > (CW+1)'(r_rad)) ? w_nr - (CW+1)'(r_rad) : '0;
        if (w_gr > r_dist) w_gr = r_dist;
    end

    logic [CW-1:0] w_newc;
    assign w_newc = w_ge ? w_c + w_q : w_c - w_q;

    assign s_in.ready  = (r_st == bsg_pkg::ST_IDLE);
    assign m_out.valid = r_valid;
    assign m_out.data  = {r_cx, r_cy, r_cz, r_rad,
                          (r_cx != r_ox) || (r_cy != r_oy) || (r_cz != r_oz) ||
                          (r_rad != r_orad) || r_empty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= bsg_pkg::ST_IDLE;
            r_valid   <= 1'b0;
            r_empty   <= 1'b1;
            r_div_run <= 1'b0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_cz      <= '0;
            r_rad     <= '0;
            r_ax      <= '0;
        end else begin
            unique case (r_st)
                bsg_pkg::ST_IDLE: begin
                    if (s_in.valid) begin
                        r_ix <= w_x; r_iy <= w_y; r_iz <= w_z; r_ir <= w_r;
                        r_ox <= r_cx; r_oy <= r_cy; r_oz <= r_cz; r_orad <= r_rad;
                        r_ax  <= '0;
                        r_sum <= '0;
                        if (w_restart || r_empty) begin
                            r_empty <= 1'b1;
                            r_cx <= w_x; r_cy <= w_y; r_cz <= w_z; r_rad <= w_r;
                            r_valid <= 1'b1;
                            r_st <= bsg_pkg::ST_OUT;
                        end else begin
                            r_st <= bsg_pkg::ST_SQR;
                        end
                    end
                end
                bsg_pkg::ST_SQR: begin
                    r_sum <= w_add[SW] ? {SW{1'b1}} : w_add[SW-1:0];
                    if (r_ax == 2'd2) begin
                        r_st <= bsg_pkg::ST_ROOT;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                bsg_pkg::ST_ROOT: begin
                    if (w_sq_done) begin
                        r_dist <= {1'b0, w_root};
                        r_st   <= bsg_pkg::ST_DEC;
                    end
                end
                bsg_pkg::ST_DEC: begin
                    r_ax <= '0;
                    if (w_in_sum <= (CW+2)'(r_rad)) begin
                        r_valid <= 1'b1;
                        r_st    <= bsg_pkg::ST_OUT;
                    end else if (w_enc_sum <= (CW+2)'(r_ir)) begin
                        r_cx <= r_ix; r_cy <= r_iy; r_cz <= r_iz; r_rad <= r_ir;
                        r_valid <= 1'b1;
                        r_st    <= bsg_pkg::ST_OUT;
                    end else begin
                        r_rad <= w_nr[RW-1:0];
                        r_g   <= w_gr[CW-1:0];
                        if (r_dist != '0 && w_gr != '0) begin
                            r_st <= bsg_pkg::ST_DIV;
                        end else begin
                            r_valid <= 1'b1;
                            r_st    <= bsg_pkg::ST_OUT;
                        end
                    end
                end
                bsg_pkg::ST_DIV: begin
                    r_div_run <= !w_div_done;
                    if (w_div_done) begin
                        unique case (r_ax)
                            2'd0:    r_cx <= w_newc;
                            2'd1:    r_cy <= w_newc;
                            default: r_cz <= w_newc;
                        endcase
                        if (r_ax == 2'd2) begin
                            r_valid <= 1'b1;
                            r_st    <= bsg_pkg::ST_OUT;
                        end else begin
                            r_ax <= r_ax + 1'b1;
                        end
                    end
                end
                bsg_pkg::ST_OUT: begin
                    if (m_out.ready) begin
                        r_valid <= 1'b0;
                        r_empty <= 1'b0;
                        r_st    <= bsg_pkg::ST_IDLE;
                    end
                end
                default: r_st <= bsg_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
